// ===== rtl/core/owm_pkg.sv =====
package owm_pkg;

  // Command codes carried in req_type
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_RESET   = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_MEASURE = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_RESET_LOW   = 2'd0;
  localparam logic [1:0] REG_PRES_SAMPLE = 2'd1;
  localparam logic [1:0] REG_RESET_REC   = 2'd2;
  localparam logic [1:0] REG_CONV_WAIT   = 2'd3;

  // Register reset values
  localparam logic [15:0] RESET_LOW_DEF   = 16'd500;
  localparam logic [15:0] PRES_SAMPLE_DEF = 16'd100;
  localparam logic [15:0] RESET_REC_DEF   = 16'd400;
  localparam logic [19:0] CONV_WAIT_DEF   = 20'd55000;

  // ROM and function command bytes
  localparam logic [7:0] OW_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] OW_CONVERT    = 8'h44;
  localparam logic [7:0] OW_READ_SCRPD = 8'hBE;

  // Slot timing in ticks
  localparam logic [19:0] WR_LOW_END   = 20'd5;
  localparam logic [19:0] WR_SLOT_END  = 20'd60;
  localparam logic [19:0] RD_LOW_END   = 20'd2;
  localparam logic [19:0] RD_SAMPLE_AT = 20'd10;
  localparam logic [19:0] RD_SLOT_END  = 20'd15;

  // Temperature sequence steps of interest
  localparam logic [3:0] STEP_SINGLE = 4'd0;
  localparam logic [3:0] STEP_FIRST  = 4'd1;
  localparam logic [3:0] STEP_LAST   = 4'd9;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RLOW  = 3'd1,
    PH_RWAIT = 3'd2,
    PH_RREC  = 3'd3,
    PH_WSLOT = 3'd4,
    PH_RSLOT = 3'd5,
    PH_CWAIT = 3'd6
  } owm_phase_t;

  typedef struct packed {
    owm_phase_t   phase;
    logic [19:0]  tick_count;
    logic [2:0]   bit_index;
    logic [7:0]   shift_byte;
    logic [3:0]   seq_step;
    logic [15:0]  raw_temp;
    logic         presence;
    logic [7:0]   last_read;
  } owm_state_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_sample_ticks;
    logic [15:0] reset_recovery_ticks;
    logic [19:0] conversion_wait_ticks;
  } owm_cfg_t;

  typedef struct packed {
    logic               pull_low;
    logic               busy_res;
    logic               done_res;
    logic               presence;
    logic [7:0]         read_value;
    logic signed [15:0] temperature_tenths;
    logic               command_rejected;
  } owm_result_t;

endpackage

// ===== rtl/core/owm_step.sv =====
module owm_step (
  input  owm_pkg::owm_state_t  state_i,
  input  owm_pkg::owm_cfg_t    cfg_i,
  input  logic [2:0]           req_type_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_level_i,
  output owm_pkg::owm_state_t  state_o,
  output owm_pkg::owm_result_t res_o
);
  import owm_pkg::*;

  owm_state_t  s;
  logic        rej;
  logic        pull;
  logic        busy;
  logic        done;
  logic        ends;
  logic [20:0] tick_inc;
  logic [19:0] t;
  logic [15:0] half_deg;

  // Start the phase belonging to the current sequence step
  function automatic owm_state_t begin_step(input owm_state_t st);
    owm_state_t r;
    r = st;
    r.tick_count = '0;
    r.bit_index  = '0;
    unique case (st.seq_step)
      4'd1, 4'd5: r.phase = PH_RLOW;
      4'd2, 4'd6: begin
        r.phase = PH_WSLOT;
        r.shift_byte = OW_SKIP_ROM;
      end
      4'd3: begin
        r.phase = PH_WSLOT;
        r.shift_byte = OW_CONVERT;
      end
      4'd4: r.phase = PH_CWAIT;
      4'd7: begin
        r.phase = PH_WSLOT;
        r.shift_byte = OW_READ_SCRPD;
      end
      default: begin
        r.phase = PH_RSLOT;
        r.shift_byte = '0;
      end
    endcase
    return r;
  endfunction

  // Unit end: back to idle for a single command or the last step, else next step
  function automatic owm_state_t finish_unit(input owm_state_t st, output logic fin);
    owm_state_t r;
    r = st;
    r.tick_count = '0;
    r.bit_index  = '0;
    if (st.seq_step == STEP_SINGLE || st.seq_step >= STEP_LAST) begin
      r.phase    = PH_IDLE;
      r.seq_step = STEP_SINGLE;
      fin        = 1'b1;
    end else begin
      r.seq_step = st.seq_step + 4'd1;
      r          = begin_step(r);
      fin        = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    s    = state_i;
    rej  = 1'b0;
    pull = 1'b0;
    done = 1'b0;
    ends = 1'b0;

    // Command intake, only when idle
    if (req_type_i >= CMD_RESET && req_type_i <= CMD_MEASURE) begin
      if (s.phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        s.seq_step   = STEP_SINGLE;
        s.tick_count = '0;
        s.bit_index  = '0;
        unique case (req_type_i)
          CMD_RESET: s.phase = PH_RLOW;
          CMD_WRITE: begin
            s.phase = PH_WSLOT;
            s.shift_byte = write_data_i;
          end
          CMD_READ: begin
            s.phase = PH_RSLOT;
            s.shift_byte = '0;
          end
          default: begin
            s.seq_step = STEP_FIRST;
            s = begin_step(s);
          end
        endcase
      end
    end

    busy     = (s.phase != PH_IDLE);
    t        = s.tick_count;
    tick_inc = {1'b0, s.tick_count} + 21'd1;

    // Phase work for this tick
    unique case (s.phase)
      PH_IDLE: ;
      PH_RLOW: begin
        pull = 1'b1;
        if (tick_inc >= {5'd0, cfg_i.reset_low_ticks}) begin
          s.phase = PH_RWAIT;
          s.tick_count = '0;
          s.bit_index = '0;
        end else begin
          s.tick_count = tick_inc[19:0];
        end
      end
      PH_RWAIT: begin
        if (tick_inc >= {5'd0, cfg_i.presence_sample_ticks}) begin
          s.phase = PH_RREC;
          s.tick_count = '0;
          s.bit_index = '0;
        end else begin
          s.tick_count = tick_inc[19:0];
        end
      end
      PH_RREC: begin
        if (t == '0) s.presence = ~line_level_i;
        if (tick_inc >= {5'd0, cfg_i.reset_recovery_ticks}) begin
          s = finish_unit(s, ends);
          done = ends;
        end else begin
          s.tick_count = tick_inc[19:0];
        end
      end
      PH_CWAIT: begin
        if (tick_inc >= {1'b0, cfg_i.conversion_wait_ticks}) begin
          s = finish_unit(s, ends);
          done = ends;
        end else begin
          s.tick_count = tick_inc[19:0];
        end
      end
      PH_WSLOT: begin
        if (t < WR_LOW_END) pull = 1'b1;
        else if (t < WR_SLOT_END) pull = ~s.shift_byte[0];
        if (t >= WR_SLOT_END) begin
          if (s.bit_index == 3'd7) begin
            s = finish_unit(s, ends);
            done = ends;
          end else begin
            s.bit_index = s.bit_index + 3'd1;
            s.tick_count = '0;
            s.shift_byte = {1'b0, s.shift_byte[7:1]};
          end
        end else begin
          s.tick_count = tick_inc[19:0];
        end
      end
      PH_RSLOT: begin
        if (t < RD_LOW_END) pull = 1'b1;
        if (t == RD_SAMPLE_AT) s.shift_byte = {line_level_i, s.shift_byte[7:1]};
        if (t >= RD_SLOT_END) begin
          if (s.bit_index == 3'd7) begin
            if (s.seq_step == STEP_LAST) s.raw_temp = {s.shift_byte, s.last_read};
            s.last_read = s.shift_byte;
            s = finish_unit(s, ends);
            done = ends;
          end else begin
            s.bit_index = s.bit_index + 3'd1;
            s.tick_count = '0;
          end
        end else begin
          s.tick_count = tick_inc[19:0];
        end
      end
      default: s.phase = PH_IDLE;
    endcase

    // Half degrees times five gives tenths
    half_deg = {{3{s.raw_temp[15]}}, s.raw_temp[15:3]};

    state_o                  = s;
    res_o.pull_low           = pull;
    res_o.busy_res           = busy;
    res_o.done_res           = done;
    res_o.presence           = s.presence;
    res_o.read_value         = s.last_read;
    res_o.temperature_tenths = signed'({half_deg[13:0], 2'b00} + half_deg);
    res_o.command_rejected   = rej;
  end

endmodule

// ===== rtl/core/onewire_temperature_master.sv =====
// One-wire bus master, one bus tick per input item.
// Latency: the result of an item is in the output register the cycle after acceptance.
// Throughput: one item per cycle while out_tready is high; the tick step
// is a single combinational pass between the state registers and the result register.
// Reset (rst_n low, synchronous): idle, counters and captured values cleared,
// timing registers back to their defaults, output register empty.
module onewire_temperature_master (
  input  logic        clk,
  input  logic        rst_n,
  // write_data[7:0], line_level[8], zero pad [15:9]
  input  logic [15:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pull_low[0], busy_res[1], done_res[2], presence[3], read_value[11:4],
  // temperature_tenths[27:12], command_rejected[28], zero pad [31:29]
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);
  import owm_pkg::*;

  owm_state_t  state_r;
  owm_state_t  state_nxt;
  owm_cfg_t    cfg_r;
  owm_result_t res;
  logic [31:0] out_data_r;
  logic        out_valid_r;
  logic        accept;

  assign in_tready  = ~out_valid_r | out_tready;
  assign accept     = in_tvalid & in_tready;
  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  owm_step u_step (
    .state_i      (state_r),
    .cfg_i        (cfg_r),
    .req_type_i   (in_tuser),
    .write_data_i (in_tdata[7:0]),
    .line_level_i (in_tdata[8]),
    .state_o      (state_nxt),
    .res_o        (res)
  );

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks       <= RESET_LOW_DEF;
      cfg_r.presence_sample_ticks <= PRES_SAMPLE_DEF;
      cfg_r.reset_recovery_ticks  <= RESET_REC_DEF;
      cfg_r.conversion_wait_ticks <= CONV_WAIT_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:   cfg_r.reset_low_ticks       <= cfg_wdata[15:0];
        REG_PRES_SAMPLE: cfg_r.presence_sample_ticks <= cfg_wdata[15:0];
        REG_RESET_REC:   cfg_r.reset_recovery_ticks  <= cfg_wdata[15:0];
        REG_CONV_WAIT:   cfg_r.conversion_wait_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Bus state advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {3'b000, res.command_rejected, res.temperature_tenths,
                     res.read_value, res.presence, res.done_res,
                     res.busy_res, res.pull_low};
    end
  end

endmodule
